FILE: hdl/obb_pkg.sv
// shared types, widths and register codes for the oriented box point filter
package obb_pkg;

    // field widths
    localparam int IDX_W   = 24;
    localparam int COORD_W = 32;
    localparam int HALF_W  = 32;
    localparam int COMP_W  = 21;
    localparam int AXIS_W  = 3 * COMP_W;
    localparam int DATA_W  = 64;
    localparam int CIDX_W  = 4;

    // derived arithmetic widths
    localparam int OFS_W  = COORD_W + 1;
    localparam int PROD_W = OFS_W + COMP_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FRAC_SHIFT = 19;
    localparam int CMP_W  = SUM_W + 1;

    // points with an index at or past this bound are dropped
    localparam longint unsigned MAX_POINTS = 64'd16777216;

    // configuration register codes
    localparam logic [CIDX_W-1:0] REG_CENTER_X    = 4'd0;
    localparam logic [CIDX_W-1:0] REG_CENTER_Y    = 4'd1;
    localparam logic [CIDX_W-1:0] REG_CENTER_Z    = 4'd2;
    localparam logic [CIDX_W-1:0] REG_AXIS_FIRST  = 4'd3;
    localparam logic [CIDX_W-1:0] REG_AXIS_SECOND = 4'd4;
    localparam logic [CIDX_W-1:0] REG_AXIS_THIRD  = 4'd5;
    localparam logic [CIDX_W-1:0] REG_HALF_AB     = 4'd6;
    localparam logic [CIDX_W-1:0] REG_HALF_C      = 4'd7;

    // reset axes are the unit x, y and z vectors (1.0 = 2^19)
    localparam logic [AXIS_W-1:0] AXIS_FIRST_RST  = AXIS_W'(1) << FRAC_SHIFT;
    localparam logic [AXIS_W-1:0] AXIS_SECOND_RST = AXIS_W'(1) << (FRAC_SHIFT + COMP_W);
    localparam logic [AXIS_W-1:0] AXIS_THIRD_RST  = AXIS_W'(1) << (FRAC_SHIFT + 2 * COMP_W);

    // current box configuration
    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] center_z;
        logic [AXIS_W-1:0]  axis_a;
        logic [AXIS_W-1:0]  axis_b;
        logic [AXIS_W-1:0]  axis_c;
        logic [HALF_W-1:0]  half_a;
        logic [HALF_W-1:0]  half_b;
        logic [HALF_W-1:0]  half_c;
    } t_cfg;

    // stage enables for a projection unit
    typedef struct packed {
        logic en_prod;
        logic en_sum;
    } t_proj_en;

endpackage

FILE: hdl/obb_cfg.sv
// configuration register file for the box center, axes and half extents
module obb_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [obb_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [obb_pkg::DATA_W-1:0]  i_cfg_data,
    output obb_pkg::t_cfg               o_cfg
);

    obb_pkg::t_cfg r_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register update, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.center_z <= '0;
            r_cfg.axis_a   <= obb_pkg::AXIS_FIRST_RST;
            r_cfg.axis_b   <= obb_pkg::AXIS_SECOND_RST;
            r_cfg.axis_c   <= obb_pkg::AXIS_THIRD_RST;
            r_cfg.half_a   <= '0;
            r_cfg.half_b   <= '0;
            r_cfg.half_c   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                obb_pkg::REG_CENTER_X: begin
                    r_cfg.center_x <= i_cfg_data[obb_pkg::COORD_W-1:0];
                end
                obb_pkg::REG_CENTER_Y: begin
                    r_cfg.center_y <= i_cfg_data[obb_pkg::COORD_W-1:0];
                end
                obb_pkg::REG_CENTER_Z: begin
                    r_cfg.center_z <= i_cfg_data[obb_pkg::COORD_W-1:0];
                end
                obb_pkg::REG_AXIS_FIRST: begin
                    r_cfg.axis_a <= i_cfg_data[obb_pkg::AXIS_W-1:0];
                end
                obb_pkg::REG_AXIS_SECOND: begin
                    r_cfg.axis_b <= i_cfg_data[obb_pkg::AXIS_W-1:0];
                end
                obb_pkg::REG_AXIS_THIRD: begin
                    r_cfg.axis_c <= i_cfg_data[obb_pkg::AXIS_W-1:0];
                end
                obb_pkg::REG_HALF_AB: begin
                    r_cfg.half_a <= i_cfg_data[obb_pkg::HALF_W-1:0];
                    r_cfg.half_b <= i_cfg_data[2*obb_pkg::HALF_W-1:obb_pkg::HALF_W];
                end
                obb_pkg::REG_HALF_C: begin
                    r_cfg.half_c <= i_cfg_data[obb_pkg::HALF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/obb_proj.sv
// projection of the center offset onto one box axis: multiply stage, then sum stage
module obb_proj (
    input  logic                              i_clk,
    input  obb_pkg::t_proj_en                 i_en,
    input  logic signed [obb_pkg::OFS_W-1:0]  i_dx,
    input  logic signed [obb_pkg::OFS_W-1:0]  i_dy,
    input  logic signed [obb_pkg::OFS_W-1:0]  i_dz,
    input  logic [obb_pkg::AXIS_W-1:0]        i_axis,
    output logic signed [obb_pkg::SUM_W-1:0]  o_sum
);

    localparam int CW = obb_pkg::COMP_W;

    logic signed [CW-1:0]               w_ax;
    logic signed [CW-1:0]               w_ay;
    logic signed [CW-1:0]               w_az;
    logic signed [obb_pkg::PROD_W-1:0]  n_px;
    logic signed [obb_pkg::PROD_W-1:0]  n_py;
    logic signed [obb_pkg::PROD_W-1:0]  n_pz;
    logic signed [obb_pkg::PROD_W-1:0]  r_px;
    logic signed [obb_pkg::PROD_W-1:0]  r_py;
    logic signed [obb_pkg::PROD_W-1:0]  r_pz;
    logic signed [obb_pkg::SUM_W-1:0]   n_sum;
    logic signed [obb_pkg::SUM_W-1:0]   r_sum;

    // unpack the axis components
    assign w_ax = $signed(i_axis[CW-1:0]);
    assign w_ay = $signed(i_axis[2*CW-1:CW]);
    assign w_az = $signed(i_axis[3*CW-1:2*CW]);

    // exact products
    assign n_px = obb_pkg::PROD_W'(i_dx) * obb_pkg::PROD_W'(w_ax);
    assign n_py = obb_pkg::PROD_W'(i_dy) * obb_pkg::PROD_W'(w_ay);
    assign n_pz = obb_pkg::PROD_W'(i_dz) * obb_pkg::PROD_W'(w_az);

    always_ff @(posedge i_clk) begin
        if (i_en.en_prod) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
        end
    end

    // exact sum of the three products
    assign n_sum = obb_pkg::SUM_W'(r_px) + obb_pkg::SUM_W'(r_py) + obb_pkg::SUM_W'(r_pz);

    always_ff @(posedge i_clk) begin
        if (i_en.en_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

FILE: hdl/obb_point_containment_filter.sv
// Oriented bounding box point filter, top level.
// An accepted point passes through the offset, multiply, sum and compare stages in order to the output register.
// Throughput: one point per cycle while the output is not stalled, set by the four-stage pipeline
// (offset, multiply, sum, compare); points outside the box leave no result.
// Reset clears all stage valid bits and loads the default box configuration.
module obb_point_containment_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // point input
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [obb_pkg::IDX_W-1:0]          i_point_index,
    input  logic signed [obb_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [obb_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [obb_pkg::COORD_W-1:0] i_coord_z,
    // hit output
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [obb_pkg::IDX_W-1:0]          o_hit_index,
    output logic signed [obb_pkg::COORD_W-1:0] o_hit_x,
    output logic signed [obb_pkg::COORD_W-1:0] o_hit_y,
    output logic signed [obb_pkg::COORD_W-1:0] o_hit_z,
    // configuration write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [obb_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [obb_pkg::DATA_W-1:0]         i_cfg_data
);

    localparam int IW   = obb_pkg::IDX_W;
    localparam int CRW  = obb_pkg::COORD_W;
    localparam int OW   = obb_pkg::OFS_W;
    localparam int SW   = obb_pkg::SUM_W;
    localparam int CMPW = obb_pkg::CMP_W;
    localparam int FS   = obb_pkg::FRAC_SHIFT;

    obb_pkg::t_cfg     w_cfg;
    obb_pkg::t_proj_en w_en;

    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdy4;
    logic w_idx_ok;

    // stage 1: input register with center offsets
    logic                   r_v1;
    logic [IW-1:0]          r_idx1;
    logic [CRW-1:0]         r_x1;
    logic [CRW-1:0]         r_y1;
    logic [CRW-1:0]         r_z1;
    logic signed [OW-1:0]   n_dx;
    logic signed [OW-1:0]   n_dy;
    logic signed [OW-1:0]   n_dz;
    logic signed [OW-1:0]   r_dx1;
    logic signed [OW-1:0]   r_dy1;
    logic signed [OW-1:0]   r_dz1;

    // stages 2 and 3: payload carried beside the projection units
    logic                   r_v2;
    logic [IW-1:0]          r_idx2;
    logic [CRW-1:0]         r_x2;
    logic [CRW-1:0]         r_y2;
    logic [CRW-1:0]         r_z2;
    logic                   r_v3;
    logic [IW-1:0]          r_idx3;
    logic [CRW-1:0]         r_x3;
    logic [CRW-1:0]         r_y3;
    logic [CRW-1:0]         r_z3;

    logic signed [SW-1:0]   w_sum_a;
    logic signed [SW-1:0]   w_sum_b;
    logic signed [SW-1:0]   w_sum_c;

    // stage 4: compare and output register
    logic signed [CMPW-1:0] w_lim_a;
    logic signed [CMPW-1:0] w_lim_b;
    logic signed [CMPW-1:0] w_lim_c;
    logic signed [CMPW-1:0] w_s_a;
    logic signed [CMPW-1:0] w_s_b;
    logic signed [CMPW-1:0] w_s_c;
    logic                   w_inside;
    logic                   r_ov;
    logic [IW-1:0]          r_oidx;
    logic [CRW-1:0]         r_ox;
    logic [CRW-1:0]         r_oy;
    logic [CRW-1:0]         r_oz;

    // configuration registers
    obb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // stage advance: a stage loads when it is empty or its successor loads
    assign w_rdy4 = !r_ov || !i_stall;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;

    assign w_en.en_prod = w_rdy2;
    assign w_en.en_sum  = w_rdy3;

    // index range check and center offsets
    assign w_idx_ok = (64'(i_point_index) < obb_pkg::MAX_POINTS);
    assign n_dx = OW'(i_coord_x) - OW'($signed(w_cfg.center_x));
    assign n_dy = OW'(i_coord_y) - OW'($signed(w_cfg.center_y));
    assign n_dz = OW'(i_coord_z) - OW'($signed(w_cfg.center_z));

    // stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid && w_idx_ok;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_idx1 <= i_point_index;
            r_x1   <= i_coord_x;
            r_y1   <= i_coord_y;
            r_z1   <= i_coord_z;
            r_dx1  <= n_dx;
            r_dy1  <= n_dy;
            r_dz1  <= n_dz;
        end
    end

    // projections onto the three axes
    obb_proj u_proj_a (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_dx   (r_dx1),
        .i_dy   (r_dy1),
        .i_dz   (r_dz1),
        .i_axis (w_cfg.axis_a),
        .o_sum  (w_sum_a)
    );

    obb_proj u_proj_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_dx   (r_dx1),
        .i_dy   (r_dy1),
        .i_dz   (r_dz1),
        .i_axis (w_cfg.axis_b),
        .o_sum  (w_sum_b)
    );

    obb_proj u_proj_c (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_dx   (r_dx1),
        .i_dy   (r_dy1),
        .i_dz   (r_dz1),
        .i_axis (w_cfg.axis_c),
        .o_sum  (w_sum_c)
    );

    // stages 2 and 3 valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stages 2 and 3 payload
    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_idx2 <= r_idx1;
            r_x2   <= r_x1;
            r_y2   <= r_y1;
            r_z2   <= r_z1;
        end
        if (w_rdy3) begin
            r_idx3 <= r_idx2;
            r_x3   <= r_x2;
            r_y3   <= r_y2;
            r_z3   <= r_z2;
        end
    end

    // half extents scaled to the product's fraction
    assign w_lim_a = $signed(CMPW'({w_cfg.half_a, FS'(0)}));
    assign w_lim_b = $signed(CMPW'({w_cfg.half_b, FS'(0)}));
    assign w_lim_c = $signed(CMPW'({w_cfg.half_c, FS'(0)}));
    assign w_s_a   = CMPW'(w_sum_a);
    assign w_s_b   = CMPW'(w_sum_b);
    assign w_s_c   = CMPW'(w_sum_c);

    // |s| <= h as two parallel bound checks
    assign w_inside = (w_s_a <= w_lim_a) && (w_s_a >= -w_lim_a)
                   && (w_s_b <= w_lim_b) && (w_s_b >= -w_lim_b)
                   && (w_s_c <= w_lim_c) && (w_s_c >= -w_lim_c);

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_rdy4) begin
            r_ov <= r_v3 && w_inside;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_oidx <= r_idx3;
            r_ox   <= r_x3;
            r_oy   <= r_y3;
            r_oz   <= r_z3;
        end
    end

    assign o_valid     = r_ov;
    assign o_hit_index = r_oidx;
    assign o_hit_x     = $signed(r_ox);
    assign o_hit_y     = $signed(r_oy);
    assign o_hit_z     = $signed(r_oz);

endmodule
